// ----- rtl/core/qrm_pkg.sv -----
// ----------------------------------------------------------------------------
// qrm_pkg: shared types and constants for the quaternion to rotation matrix
// Word layouts, internal widths, fixed-point constants and lane numbering.
// ----------------------------------------------------------------------------
package qrm_pkg;

  localparam int DATA_WIDTH = 16;
  localparam int FRAC_BITS  = DATA_WIDTH - 2;

  // squares are non-negative and fit one bit less than a full product
  localparam int SQ_W   = 2 * DATA_WIDTH - 1;
  localparam int PROD_W = 2 * DATA_WIDTH;
  localparam int PAIR_W = 2 * DATA_WIDTH;
  localparam int NORM_W = 2 * DATA_WIDTH + 1;
  localparam int OFF_W  = 2 * DATA_WIDTH + 1;
  localparam int MAG_W  = 2 * DATA_WIDTH + 1;
  localparam int REM_W  = MAG_W + 1;

  // quotient carries one integer bit, FRAC_BITS bits and one rounding bit
  localparam int Q_W     = FRAC_BITS + 2;
  localparam int NUM_ENT = 9;

  // multiply, pair sums, norm and magnitudes, divide steps, round
  localparam int PIPE_LAT = Q_W + 4;

  localparam logic [DATA_WIDTH-1:0] ONE_VAL = DATA_WIDTH'(1) << FRAC_BITS;
  localparam logic [Q_W-1:0]        Q_MAX   = Q_W'(1) << (Q_W - 1);
  localparam logic [NORM_W-1:0]     NORM_THRESH =
    NORM_W'((64'd1 << (2 * FRAC_BITS)) / 64'd10000);

  // lane numbering, row-major
  localparam int ENT_R00 = 0;
  localparam int ENT_R01 = 1;
  localparam int ENT_R02 = 2;
  localparam int ENT_R10 = 3;
  localparam int ENT_R11 = 4;
  localparam int ENT_R12 = 5;
  localparam int ENT_R20 = 6;
  localparam int ENT_R21 = 7;
  localparam int ENT_R22 = 8;

  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] quat_w;
    logic signed [DATA_WIDTH-1:0] quat_x;
    logic signed [DATA_WIDTH-1:0] quat_y;
    logic signed [DATA_WIDTH-1:0] quat_z;
  } quat_in_t;

  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] r00;
    logic signed [DATA_WIDTH-1:0] r01;
    logic signed [DATA_WIDTH-1:0] r02;
    logic signed [DATA_WIDTH-1:0] r10;
    logic signed [DATA_WIDTH-1:0] r11;
    logic signed [DATA_WIDTH-1:0] r12;
    logic signed [DATA_WIDTH-1:0] r20;
    logic signed [DATA_WIDTH-1:0] r21;
    logic signed [DATA_WIDTH-1:0] r22;
    logic                         norm_error;
  } rot_out_t;

  typedef logic [NUM_ENT-1:0][MAG_W-1:0] mag_vec_t;
  typedef logic [NUM_ENT-1:0][Q_W-1:0]   quo_vec_t;

  // control that rides along the divider stages
  typedef struct packed {
    logic               valid;
    logic               err;
    logic [NUM_ENT-1:0] neg;
  } div_side_t;

endpackage

// ----- rtl/core/qrm_div_pipe.sv -----
// ----------------------------------------------------------------------------
// qrm_div_pipe: nine-lane pipelined restoring divider
// One quotient bit per stage for each lane, all lanes sharing one divisor.
// ----------------------------------------------------------------------------
module qrm_div_pipe import qrm_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  div_side_t           side_in,
  input  logic [NORM_W-1:0]   norm_in,
  input  mag_vec_t            mag_in,
  output div_side_t           side_out,
  output quo_vec_t            quo_out
);

  div_side_t                     side_r [Q_W];
  logic [NORM_W-1:0]             norm_r [Q_W];
  quo_vec_t                      quo_r  [Q_W];
  logic [NUM_ENT-1:0][MAG_W-1:0] rem_r  [Q_W-1];

  genvar s;
  generate
    for (s = 0; s < Q_W; s++) begin : g_stage
      div_side_t                     src_side;
      logic [NORM_W-1:0]             src_norm;
      quo_vec_t                      src_quo;
      logic [NUM_ENT-1:0][REM_W-1:0] src_rem;
      quo_vec_t                      quo_nxt;
      logic [NUM_ENT-1:0][MAG_W-1:0] rem_nxt;

      if (s == 0) begin : g_first
        // first step takes the integer bit, no shift
        always_comb begin
          src_side = side_in;
          src_norm = norm_in;
          src_quo  = '0;
          for (int l = 0; l < NUM_ENT; l++) begin
            src_rem[l] = {1'b0, mag_in[l]};
          end
        end
      end else begin : g_rest
        always_comb begin
          src_side = side_r[s-1];
          src_norm = norm_r[s-1];
          src_quo  = quo_r[s-1];
          for (int l = 0; l < NUM_ENT; l++) begin
            src_rem[l] = {rem_r[s-1][l], 1'b0};
          end
        end
      end

      always_comb begin
        logic [REM_W-1:0] dif;
        logic             ge;
        for (int l = 0; l < NUM_ENT; l++) begin
          dif = src_rem[l] - {1'b0, src_norm};
          ge  = src_rem[l] >= {1'b0, src_norm};
          quo_nxt[l] = {src_quo[l][Q_W-2:0], ge};
          rem_nxt[l] = ge ? dif[MAG_W-1:0] : src_rem[l][MAG_W-1:0];
        end
      end

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          side_r[s].valid <= 1'b0;
        end else begin
          side_r[s].valid <= src_side.valid;
        end
        side_r[s].err <= src_side.err;
        side_r[s].neg <= src_side.neg;
        norm_r[s]     <= src_norm;
        quo_r[s]      <= quo_nxt;
      end

      if (s < Q_W - 1) begin : g_keep_rem
        always_ff @(posedge clk) begin
          rem_r[s] <= rem_nxt;
        end
      end
    end
  endgenerate

  assign side_out = side_r[Q_W-1];
  assign quo_out  = quo_r[Q_W-1];

  // numerators never exceed the norm, so no lane goes above one; checked on lanes R00, R11, R22 and R01
  a_quo_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (side_out.valid && !side_out.err) |->
      (quo_out[ENT_R00] <= Q_MAX && quo_out[ENT_R11] <= Q_MAX &&
       quo_out[ENT_R22] <= Q_MAX && quo_out[ENT_R01] <= Q_MAX))
    else $error("divider quotient above one on a valid word");

endmodule

// ----- rtl/core/quaternion_to_rotation_matrix.sv -----
// ----------------------------------------------------------------------------
// quaternion_to_rotation_matrix: quaternion to 3x3 rotation matrix
// Converts one signed Q2.14 quaternion to nine Q2.14 matrix entries.
// ----------------------------------------------------------------------------
// A quaternion word is taken whenever start is high and busy is low; busy
// is high only during reset and the cycle after it, so one word per cycle
// is accepted. Each result appears on out_data for one cycle with out_valid
// high, in order; the receiver cannot stall it. Every entry is the exact
// ratio of a numerator to the squared norm, rounded to nearest, and that
// ratio is built one quotient bit per stage (16 stages), after one
// multiply stage and two add stages, with one rounding stage at the end.
// A squared norm at or below 0.0001 gives the identity with norm_error set.
// ----------------------------------------------------------------------------
module quaternion_to_rotation_matrix import qrm_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  input  quat_in_t in_data,
  output logic     out_valid,
  output rot_out_t out_data
);

  logic in_accept;
  logic busy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
    end else begin
      busy_r <= 1'b0;
    end
  end

  assign busy      = busy_r;
  assign in_accept = start && !busy_r;

  // ---- stage 1: products ----
  logic                     v1_r;
  logic signed [PROD_W-1:0] p_ww, p_xx, p_yy, p_zz;
  logic signed [PROD_W-1:0] p_xy, p_wz, p_xz, p_wy, p_yz, p_wx;
  logic [SQ_W-1:0]          sq_w_r, sq_x_r, sq_y_r, sq_z_r;
  logic signed [PROD_W-1:0] xy_r, wz_r, xz_r, wy_r, yz_r, wx_r;

  assign p_ww = in_data.quat_w * in_data.quat_w;
  assign p_xx = in_data.quat_x * in_data.quat_x;
  assign p_yy = in_data.quat_y * in_data.quat_y;
  assign p_zz = in_data.quat_z * in_data.quat_z;
  assign p_xy = in_data.quat_x * in_data.quat_y;
  assign p_wz = in_data.quat_w * in_data.quat_z;
  assign p_xz = in_data.quat_x * in_data.quat_z;
  assign p_wy = in_data.quat_w * in_data.quat_y;
  assign p_yz = in_data.quat_y * in_data.quat_z;
  assign p_wx = in_data.quat_w * in_data.quat_x;

  always_ff @(posedge clk) begin
    sq_w_r <= p_ww[SQ_W-1:0];
    sq_x_r <= p_xx[SQ_W-1:0];
    sq_y_r <= p_yy[SQ_W-1:0];
    sq_z_r <= p_zz[SQ_W-1:0];
    xy_r   <= p_xy;
    wz_r   <= p_wz;
    xz_r   <= p_xz;
    wy_r   <= p_wy;
    yz_r   <= p_yz;
    wx_r   <= p_wx;
  end

  // ---- stage 2: pair sums of squares and cross-term sums ----
  logic                    v2_r;
  logic [PAIR_W-1:0]       s_wx_r, s_yz_r, s_wy_r, s_xz_r, s_wz_r, s_xy_r;
  logic signed [OFF_W-1:0] o01_r, o02_r, o10_r, o12_r, o20_r, o21_r;

  always_ff @(posedge clk) begin
    s_wx_r <= {1'b0, sq_w_r} + {1'b0, sq_x_r};
    s_yz_r <= {1'b0, sq_y_r} + {1'b0, sq_z_r};
    s_wy_r <= {1'b0, sq_w_r} + {1'b0, sq_y_r};
    s_xz_r <= {1'b0, sq_x_r} + {1'b0, sq_z_r};
    s_wz_r <= {1'b0, sq_w_r} + {1'b0, sq_z_r};
    s_xy_r <= {1'b0, sq_x_r} + {1'b0, sq_y_r};
    o01_r  <= {xy_r[PROD_W-1], xy_r} - {wz_r[PROD_W-1], wz_r};
    o02_r  <= {xz_r[PROD_W-1], xz_r} + {wy_r[PROD_W-1], wy_r};
    o10_r  <= {xy_r[PROD_W-1], xy_r} + {wz_r[PROD_W-1], wz_r};
    o12_r  <= {yz_r[PROD_W-1], yz_r} - {wx_r[PROD_W-1], wx_r};
    o20_r  <= {xz_r[PROD_W-1], xz_r} - {wy_r[PROD_W-1], wy_r};
    o21_r  <= {yz_r[PROD_W-1], yz_r} + {wx_r[PROD_W-1], wx_r};
  end

  // ---- stage 3: norm, signs and magnitudes ----
  function automatic logic [MAG_W:0] diag_sm(logic [PAIR_W-1:0] a, logic [PAIR_W-1:0] b);
    logic [PAIR_W-1:0] d;
    logic              lt;
    lt = a < b;
    d  = lt ? (b - a) : (a - b);
    return {lt, 1'b0, d};
  endfunction

  function automatic logic [MAG_W:0] off_sm(logic signed [OFF_W-1:0] v);
    logic [OFF_W-1:0] a;
    logic             ng;
    ng = v[OFF_W-1];
    a  = ng ? (-v) : v;
    // doubled cross term
    return {ng, a[OFF_W-2:0], 1'b0};
  endfunction

  logic                     v3_r;
  logic [NORM_W-1:0]        norm_r;
  mag_vec_t                 mag_r;
  logic [NUM_ENT-1:0]       neg_r;
  logic [NUM_ENT-1:0][MAG_W:0] sm_nxt;

  always_comb begin
    sm_nxt[ENT_R00] = diag_sm(s_wx_r, s_yz_r);
    sm_nxt[ENT_R11] = diag_sm(s_wy_r, s_xz_r);
    sm_nxt[ENT_R22] = diag_sm(s_wz_r, s_xy_r);
    sm_nxt[ENT_R01] = off_sm(o01_r);
    sm_nxt[ENT_R02] = off_sm(o02_r);
    sm_nxt[ENT_R10] = off_sm(o10_r);
    sm_nxt[ENT_R12] = off_sm(o12_r);
    sm_nxt[ENT_R20] = off_sm(o20_r);
    sm_nxt[ENT_R21] = off_sm(o21_r);
  end

  always_ff @(posedge clk) begin
    norm_r <= {1'b0, s_wx_r} + {1'b0, s_yz_r};
    for (int l = 0; l < NUM_ENT; l++) begin
      neg_r[l] <= sm_nxt[l][MAG_W];
      mag_r[l] <= sm_nxt[l][MAG_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= in_accept;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  // ---- divider ----
  div_side_t div_in, div_out;
  quo_vec_t  quo;

  always_comb begin
    div_in.valid = v3_r;
    div_in.err   = norm_r <= NORM_THRESH;
    div_in.neg   = neg_r;
  end

  qrm_div_pipe u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .side_in  (div_in),
    .norm_in  (norm_r),
    .mag_in   (mag_r),
    .side_out (div_out),
    .quo_out  (quo)
  );

  // ---- output stage: round half away from zero, sign, identity on error ----
  logic [NUM_ENT-1:0][DATA_WIDTH-1:0] ent;
  rot_out_t                           out_nxt;
  rot_out_t                           out_r;
  logic                               out_valid_r;

  always_comb begin
    logic [Q_W:0]      inc;
    logic [Q_W-1:0]    rnd;
    logic [DATA_WIDTH-1:0] mag;
    for (int l = 0; l < NUM_ENT; l++) begin
      inc = {1'b0, quo[l]} + (Q_W + 1)'(1);
      rnd = inc[Q_W:1];
      mag = (rnd > Q_W'(ONE_VAL)) ? ONE_VAL : DATA_WIDTH'(rnd);
      if (div_out.err) begin
        ent[l] = (l == ENT_R00 || l == ENT_R11 || l == ENT_R22) ? ONE_VAL : '0;
      end else begin
        ent[l] = div_out.neg[l] ? (-mag) : mag;
      end
    end
    out_nxt.r00        = ent[ENT_R00];
    out_nxt.r01        = ent[ENT_R01];
    out_nxt.r02        = ent[ENT_R02];
    out_nxt.r10        = ent[ENT_R10];
    out_nxt.r11        = ent[ENT_R11];
    out_nxt.r12        = ent[ENT_R12];
    out_nxt.r20        = ent[ENT_R20];
    out_nxt.r21        = ent[ENT_R21];
    out_nxt.r22        = ent[ENT_R22];
    out_nxt.norm_error = div_out.err;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= div_out.valid;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(in_accept, PIPE_LAT))
    else $error("result word without a matching accepted word");

  a_identity: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.norm_error) |->
      (out_data.r00 == ONE_VAL && out_data.r11 == ONE_VAL &&
       out_data.r22 == ONE_VAL && out_data.r01 == '0 && out_data.r12 == '0))
    else $error("small norm did not give the identity");

  a_diag_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |->
      ($signed(out_data.r00) <= $signed(ONE_VAL) &&
       $signed(out_data.r00) >= -$signed(ONE_VAL) &&
       $signed(out_data.r11) <= $signed(ONE_VAL) &&
       $signed(out_data.r11) >= -$signed(ONE_VAL)))
    else $error("diagonal entry outside one");

endmodule
